@@ design/sm3_pkg.sv @@
// sm3_pkg: types and constants shared by the sm3 hash engine modules
// no dependencies
package sm3_pkg;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_PAD,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_COMPRESS,
		ST_OUTPUT
	} sm3_state_t;

	typedef struct packed {
		logic       load_word;
		logic [1:0] word_sel;
		logic       start_round;
		logic       round_en;
		logic       finish;
		logic       cv_reset;
		logic       out_shift;
		logic       count_clear;
	} sm3_cmd_t;

	typedef struct packed {
		logic       block_full;
		logic [3:0] word_pos;
		logic       round_last;
	} sm3_stat_t;

	localparam logic [1:0] SEL_DATA = 2'd0;
	localparam logic [1:0] SEL_ZERO = 2'd1;
	localparam logic [1:0] SEL_HI   = 2'd2;
	localparam logic [1:0] SEL_LO   = 2'd3;

	localparam logic [31:0] T_LOW  = 32'h79cc4519;
	localparam logic [31:0] T_HIGH = 32'h7a879d8a;
	localparam logic [31:0] PAD_BYTE = 32'h00000080;

	localparam logic [255:0] SM3_IV = {
		32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
		32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
	};

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

@@ design/sm3_hash_engine.sv @@
// sm3_hash_engine: sm3 hash over a stream of 32-bit big-endian words
// depends on sm3_pkg, sm3_ctrl and sm3_datapath
//
// input transfers carry one message word, a byte count and a last flag.
// full words fill a 16-word block; the 16th word starts a compression,
// one round per cycle, during which s_tready is low. the last word is
// padded (0x80, zeros, 64-bit bit length), taking up to two compressions.
// eight digest words then leave on the master side, word 0 first,
// tlast on the eighth; a stalled receiver holds the word and the block.
// after the eighth transfer the chaining value is back at the iv.
// reset clears the counters and loads the iv.
//
module sm3_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // data_word[31:0], bytes_valid[34:32], zero fill
	input  logic        s_tlast,  // last_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // digest_word[31:0]
	output logic        m_tlast   // digest_last
);
	import sm3_pkg::*;

	sm3_cmd_t    cmd, cmd_c;
	sm3_stat_t   stat;
	logic [1:0]  mode;
	logic [2:0]  nb;
	logic [31:0] word, mask, padw;
	logic [6:0]  bits;

	assign nb = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
	always_comb begin
		unique case (nb)
			3'd0: mask = 32'h00000000;
			3'd1: mask = 32'hff000000;
			3'd2: mask = 32'hffff0000;
			3'd3: mask = 32'hffffff00;
			default: mask = 32'hffffffff;
		endcase
		unique case (nb)
			3'd0: padw = PAD_BYTE << 24;
			3'd1: padw = PAD_BYTE << 16;
			3'd2: padw = PAD_BYTE << 8;
			3'd3: padw = PAD_BYTE;
			default: padw = 32'h0;
		endcase
	end

	always_comb begin
		cmd_c = cmd;
		word  = s_tdata[31:0];
		bits  = '0;
		if (s_tvalid && s_tready) begin
			if (s_tlast) begin
				word = (s_tdata[31:0] & mask) | padw;
				bits = {1'b0, nb, 3'b000};
			end else if (nb != 3'd0) bits = 7'd32;
		end
		if (mode == 2'd1 && !s_tready) begin
			cmd_c.word_sel = SEL_DATA;
			word = PAD_BYTE << 24;
		end
	end

	sm3_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.nbytes(nb), .last_in(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
		.data_mode(mode), .cmd(cmd), .stat(stat)
	);

	sm3_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_c), .stat(stat),
		.in_word(word), .bit_add(bits), .digest_word(m_tdata)
	);
endmodule

@@ design/sm3_datapath.sv @@
// sm3_datapath: block buffer, bit counter, round logic and chaining value
// depends on sm3_pkg
module sm3_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  sm3_pkg::sm3_cmd_t cmd,
	output sm3_pkg::sm3_stat_t stat,
	input  logic [31:0]       in_word,
	input  logic [6:0]        bit_add,
	output logic [31:0]       digest_word
);
	import sm3_pkg::*;

	logic [31:0] buf_q [16];
	logic [31:0] win_q [16];
	logic [3:0]  pos_q;
	logic [63:0] count_q;
	logic [5:0]  round_q;
	logic [255:0] cv_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [31:0] push_w;
	logic [31:0] wj, wj4, tj, a12, ss1, ss2, ff, gg, tt1, tt2, nxt;
	logic [3:0]  r;

	always_comb begin
		unique case (cmd.word_sel)
			SEL_DATA: push_w = in_word;
			SEL_ZERO: push_w = '0;
			SEL_HI:   push_w = count_q[63:32];
			SEL_LO:   push_w = count_q[31:0];
			default:  push_w = '0;
		endcase
	end

	assign r   = round_q[3:0];
	assign wj  = win_q[r];
	assign wj4 = win_q[r + 4'd4];
	assign tj  = (round_q < 6'd16) ? T_LOW : T_HIGH;
	assign a12 = rotl(a_q, 5'd12);
	assign ss1 = rotl(a12 + e_q + rotl(tj, round_q[4:0]), 5'd7);
	assign ss2 = ss1 ^ a12;
	assign ff  = (round_q < 6'd16) ? (a_q ^ b_q ^ c_q)
		: ((a_q & b_q) | (a_q & c_q) | (b_q & c_q));
	assign gg  = (round_q < 6'd16) ? (e_q ^ f_q ^ g_q) : ((e_q & f_q) | (~e_q & g_q));
	assign tt1 = ff + d_q + ss2 + (wj ^ wj4);
	assign tt2 = gg + h_q + ss1 + wj;
	assign nxt = perm1(wj ^ win_q[r + 4'd7] ^ rotl(win_q[r + 4'd13], 5'd15))
		^ rotl(win_q[r + 4'd3], 5'd7) ^ win_q[r + 4'd10];

	assign stat.block_full = (pos_q == 4'd15);
	assign stat.word_pos   = pos_q;
	assign stat.round_last = (round_q == 6'd63);
	assign digest_word     = cv_q[31:0];

	always_ff @(posedge clk) begin
		if (cmd.load_word) buf_q[pos_q] <= push_w;
		if (cmd.start_round) begin
			for (int i = 0; i < 15; i++) win_q[i] <= buf_q[i];
			win_q[15] <= push_w;
			{h_q, g_q, f_q, e_q, d_q, c_q, b_q, a_q} <= cv_q;
		end else if (cmd.round_en) begin
			win_q[r] <= nxt;
			d_q <= c_q; c_q <= rotl(b_q, 5'd9); b_q <= a_q; a_q <= tt1;
			h_q <= g_q; g_q <= rotl(f_q, 5'd19); f_q <= e_q; e_q <= perm0(tt2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			count_q <= '0;
			round_q <= '0;
			cv_q    <= SM3_IV;
		end else begin
			if (cmd.load_word) pos_q <= pos_q + 4'd1;
			if (cmd.count_clear) count_q <= '0;
			else count_q <= count_q + {57'd0, bit_add};
			if (cmd.start_round) round_q <= '0;
			else if (cmd.round_en) round_q <= round_q + 6'd1;
			if (cmd.cv_reset) cv_q <= SM3_IV;
			else if (cmd.finish)
				cv_q <= cv_q ^ {g_q, rotl(f_q, 5'd19), e_q, perm0(tt2), c_q,
					rotl(b_q, 5'd9), a_q, tt1};
			else if (cmd.out_shift) cv_q <= {cv_q[31:0], cv_q[255:32]};
		end
	end
endmodule

@@ design/sm3_ctrl.sv @@
// sm3_ctrl: sequencing of word intake, padding, compression and digest output
// depends on sm3_pkg
module sm3_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [2:0]         nbytes,
	input  logic               last_in,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic               m_tlast,
	output logic [1:0]         data_mode,
	output sm3_pkg::sm3_cmd_t  cmd,
	input  sm3_pkg::sm3_stat_t stat
);
	import sm3_pkg::*;

	sm3_state_t state_q, state_d, ret_q, ret_d;
	logic [2:0] out_cnt_q;
	logic       acc;
	logic       full4;
	logic [1:0] mode_q, mode_d;

	assign acc   = s_tvalid && s_tready;
	assign full4 = (nbytes >= 3'd4);
	assign data_mode = mode_q;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		mode_d  = mode_q;
		unique case (state_q)
			ST_COLLECT: if (acc) begin
				if (!last_in) begin
					if (nbytes != 3'd0 && stat.block_full) begin
						state_d = ST_COMPRESS; ret_d = ST_COLLECT;
					end
				end else if (full4) begin
					mode_d = 2'd1;
					if (stat.block_full) begin
						state_d = ST_COMPRESS; ret_d = ST_PAD;
					end else state_d = ST_PAD;
				end else begin
					mode_d = 2'd0;
					if (stat.block_full) begin
						state_d = ST_COMPRESS; ret_d = ST_PAD;
					end else state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (stat.block_full) begin
					state_d = ST_COMPRESS; ret_d = ST_PAD; mode_d = 2'd0;
				end else if (stat.word_pos == 4'd14 && mode_q == 2'd0) state_d = ST_LEN_HI;
				else mode_d = 2'd0;
			end
			ST_LEN_HI: state_d = ST_LEN_LO;
			ST_LEN_LO: begin state_d = ST_COMPRESS; ret_d = ST_OUTPUT; end
			ST_COMPRESS: if (stat.round_last) state_d = ret_q;
			ST_OUTPUT: if (m_tready && out_cnt_q == 3'd7) state_d = ST_COLLECT;
			default: state_d = ST_COLLECT;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_COLLECT: begin
				s_tready = 1'b1;
				cmd.word_sel = SEL_DATA;
				cmd.load_word = acc && (nbytes != 3'd0 || last_in) && !(last_in && !full4 && 1'b0);
				cmd.start_round = cmd.load_word && stat.block_full;
			end
			ST_PAD: begin
				cmd.word_sel = SEL_ZERO;
				cmd.load_word = !(stat.word_pos == 4'd14 && mode_q == 2'd0);
				cmd.start_round = cmd.load_word && stat.block_full;
			end
			ST_LEN_HI: begin cmd.word_sel = SEL_HI; cmd.load_word = 1'b1; end
			ST_LEN_LO: begin
				cmd.word_sel = SEL_LO; cmd.load_word = 1'b1; cmd.start_round = 1'b1;
			end
			ST_COMPRESS: begin
				cmd.round_en = 1'b1;
				cmd.finish = stat.round_last;
			end
			ST_OUTPUT: begin
				m_tvalid = 1'b1;
				cmd.out_shift = m_tready;
				cmd.cv_reset = m_tready && out_cnt_q == 3'd7;
				cmd.count_clear = cmd.cv_reset;
			end
			default: ;
		endcase
	end

	assign m_tlast = (out_cnt_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_COLLECT;
			ret_q     <= ST_COLLECT;
			mode_q    <= 2'd0;
			out_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			mode_q  <= mode_d;
			if (state_q == ST_OUTPUT && m_tready) out_cnt_q <= out_cnt_q + 3'd1;
		end
	end
endmodule

@@ design/sm3_hash_engine_checker.sv @@
// sm3_hash_engine_checker: port-level checks on the sm3 hash engine
// depends on sm3_hash_engine, bound below
module sm3_hash_engine_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic        m_tlast,
	input logic [31:0] m_tdata
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_tvalid && s_tready)) else $error("input open during digest output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled digest word changed");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("output continued after last digest word");
endmodule

bind sm3_hash_engine sm3_hash_engine_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tlast(m_tlast), .m_tdata(m_tdata)
);

@@ tb/tb_sm3_hash_engine.sv @@
// tb_sm3_hash_engine: self-checking bench for the sm3 hash engine
// drives word streams through the slave side, predicts each digest in the bench
// and checks the eight master-side transfers; depends on sm3_pkg and the rtl
module tb_sm3_hash_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] IV0 = 32'h7380166f, IV1 = 32'h4914b2b9, IV2 = 32'h172442d7,
		IV3 = 32'hda8a0600, IV4 = 32'ha96f30bc, IV5 = 32'h163138aa,
		IV6 = 32'he38dee4d, IV7 = 32'hb0fb0e4e;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic        last;
	} word_t;

	typedef struct packed {
		logic [31:0] digest;
		logic        dlast;
	} dig_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;

	sm3_hash_engine dut (.*);

	always #10 clk = ~clk;

	word_t       pending_words[$];
	dig_t        expected_digests[$];
	logic [31:0] cv[8];
	logic [31:0] blk[16];
	int          wpos;
	logic [63:0] bitcount;
	int          errors = 0;
	int          cycles = 0;
	bit          hold = 0;
	bit          pause_req = 0;

	function automatic logic [31:0] rl(logic [31:0] x, int n);
		n = n % 32;
		return n == 0 ? x : (x << n) | (x >> (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w[16];
		logic [31:0] a, b, c, d, e, f, g, h, t, a12, ss1, ss2, ff, gg, tt1, tt2, wj, nx;
		w = blk;
		a = cv[0]; b = cv[1]; c = cv[2]; d = cv[3];
		e = cv[4]; f = cv[5]; g = cv[6]; h = cv[7];
		for (int j = 0; j < 64; j++) begin
			wj = w[j % 16];
			t = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
			a12 = rl(a, 12);
			ss1 = rl(a12 + e + rl(t, j), 7);
			ss2 = ss1 ^ a12;
			if (j < 16) begin
				ff = a ^ b ^ c;
				gg = e ^ f ^ g;
			end else begin
				ff = (a & b) | (a & c) | (b & c);
				gg = (e & f) | (~e & g);
			end
			tt1 = ff + d + ss2 + (wj ^ w[(j + 4) % 16]);
			tt2 = gg + h + ss1 + wj;
			d = c; c = rl(b, 9); b = a; a = tt1;
			h = g; g = rl(f, 19); f = e; e = tt2 ^ rl(tt2, 9) ^ rl(tt2, 17);
			nx = wj ^ w[(j + 7) % 16] ^ rl(w[(j + 13) % 16], 15);
			nx = nx ^ rl(nx, 15) ^ rl(nx, 23);
			w[j % 16] = nx ^ rl(w[(j + 3) % 16], 7) ^ w[(j + 10) % 16];
		end
		cv[0] ^= a; cv[1] ^= b; cv[2] ^= c; cv[3] ^= d;
		cv[4] ^= e; cv[5] ^= f; cv[6] ^= g; cv[7] ^= h;
	endtask

	task automatic absorb_word(logic [31:0] x);
		blk[wpos] = x;
		wpos++;
		if (wpos == 16) begin
			compress_block();
			wpos = 0;
		end
	endtask

	task automatic reset_hash();
		cv = '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
		wpos = 0;
		bitcount = '0;
	endtask

	task automatic predict_word(word_t it);
		int n;
		logic [31:0] mask;
		n = it.nbytes > 4 ? 4 : it.nbytes;
		if (!it.last) begin
			if (n == 0)
				return;
			bitcount += 64'd32;
			absorb_word(it.data);
			return;
		end
		bitcount += 64'(n * 8);
		if (n == 4) begin
			absorb_word(it.data);
			absorb_word(32'h80000000);
		end else begin
			mask = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
			absorb_word((it.data & mask) | (32'h80 << (24 - 8 * n)));
		end
		while (wpos != 14)
			absorb_word(32'h0);
		absorb_word(bitcount[63:32]);
		absorb_word(bitcount[31:0]);
		for (int k = 0; k < 8; k++)
			expected_digests.push_back('{cv[k], k == 7});
		reset_hash();
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	// message of len full words then a last word with nb bytes
	task automatic queue_message(int len, int nb);
		word_t it;
		for (int i = 0; i < len; i++) begin
			it = '{$urandom, 3'd4, 1'b0};
			pending_words.push_back(it);
		end
		it = '{$urandom, 3'(nb), 1'b1};
		pending_words.push_back(it);
	endtask

	// driver
	int     gap = 0;
	word_t  cur;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_word(cur);
				pending_words.pop_front();
				gap <= $urandom_range(0, 8) * ($urandom_range(0, 3) != 0);
				s_tvalid <= 1'b0;
			end else if (!s_tvalid) begin
				if (gap > 0)
					gap <= gap - 1;
				else if (pending_words.size() > 0 && !pause_req) begin
					cur = pending_words[0];
					s_tdata <= {5'b0, cur.nbytes, cur.data};
					s_tlast <= cur.last;
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// monitor
	int sink_gap = 0;
	dig_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_digests.size() == 0)
					report("unexpected digest transfer", m_tdata, 32'h0);
				else begin
					want = expected_digests.pop_front();
					if (m_tdata !== want.digest)
						report("digest word", m_tdata, want.digest);
					if (m_tlast !== want.dlast)
						report("digest last", 32'(m_tlast), 32'(want.dlast));
				end
				sink_gap = $urandom_range(0, 8) * ($urandom_range(0, 2) != 0);
			end
			if (hold)
				m_tready <= 1'b0;
			else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		word_t it;
		reset_hash();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// directed: empty message, each byte count, extremes, ignored and oversize counts
		queue_message(0, 0);
		for (int nb = 1; nb <= 4; nb++)
			queue_message(0, nb);
		pending_words.push_back('{32'hffffffff, 3'd0, 1'b0});
		pending_words.push_back('{32'hffffffff, 3'd2, 1'b0});
		pending_words.push_back('{32'h00000000, 3'd7, 1'b0});
		pending_words.push_back('{32'hffffffff, 3'd5, 1'b1});
		queue_message(13, 3);
		queue_message(14, 4);
		wait (pending_words.size() == 0);
		// pause until all digests are back
		pause_req = 1;
		wait (expected_digests.size() == 0);
		pause_req = 0;
		// long receiver hold-off while messages keep coming
		fork
			begin
				hold = 1;
				repeat (400) @(posedge clk);
				hold = 0;
			end
		join_none
		queue_message(2, 1);
		queue_message(1, 6);
		queue_message(0, 4);
		for (int i = 0; i < 12; i++)
			queue_message($urandom_range(0, 2) ? $urandom_range(0, 5) : $urandom_range(6, 20),
				$urandom_range(0, 7));
		for (int i = 0; i < 8; i++) begin
			it = '{$urandom, 3'($urandom_range(0, 7)), 1'b0};
			pending_words.push_back(it);
		end
		queue_message(1, $urandom_range(0, 7));
		wait (pending_words.size() == 0 && !s_tvalid);
		wait (expected_digests.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
